>>> src/assert_macros.svh
// Assertion helpers for the histogram block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HLP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define HLP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HLP_ASSERT(lbl, clk, rstn, prop, msg)
`define HLP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> src/hlp_pkg.sv
// ----------------------------------------------------------------------------
// hlp_pkg
// Shared constants and types of the latency histogram percentile block.
// ----------------------------------------------------------------------------
package hlp_pkg;
  localparam int HIST_BINS = 1024;
  localparam int IDX_W     = $clog2(HIST_BINS);
  localparam int RCV_W     = IDX_W + 1;
  localparam int CNT_W     = 32;
  localparam int TOT_W     = 42;
  localparam int WSUM_W    = 52;
  localparam int ACC_W     = 49;
  localparam int OIDX_W    = 10;
  localparam int DIV_STEPS = OIDX_W;
  localparam int DSTEP_W   = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_LOAD, ST_PREP, ST_DIV, ST_SCAN, ST_DONE
  } hlp_state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic scan_step;
    logic emit;
  } hlp_cmd_t;

  typedef struct packed {
    logic div_last;
    logic scan_done;
    logic total_zero;
  } hlp_stat_t;
endpackage

>>> src/hlp_ctrl.sv
// ----------------------------------------------------------------------------
// hlp_ctrl
// Sequencer: load bins, prepare, divide, scan the store, emit one result; a zero total skips divide and scan.
// ----------------------------------------------------------------------------
module hlp_ctrl import hlp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      last_bin,
  input  hlp_stat_t stat,
  output hlp_cmd_t  cmd,
  output logic      busy
);
  hlp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_LOAD: begin
        busy     = 1'b0;
        cmd.load = start;
        if (start && last_bin) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = stat.total_zero ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end
endmodule

>>> src/hlp_dpath.sv
// ----------------------------------------------------------------------------
// hlp_dpath
// Bin store, running sums, bit-serial divider and percentile scan pipeline.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module hlp_dpath import hlp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  hlp_cmd_t           cmd,
  input  logic [CNT_W-1:0]   in_bin_count,
  output hlp_stat_t          stat,
  output logic               out_valid,
  output logic [TOT_W-1:0]   out_total_count,
  output logic [OIDX_W-1:0]  out_min_bin,
  output logic [OIDX_W-1:0]  out_max_bin,
  output logic [OIDX_W-1:0]  out_avg_bin,
  output logic [OIDX_W-1:0]  out_p50_bin,
  output logic [OIDX_W-1:0]  out_p90_bin,
  output logic [OIDX_W-1:0]  out_p95_bin,
  output logic [OIDX_W-1:0]  out_p99_bin,
  output logic               out_bins_dropped
);
  logic [CNT_W-1:0]  mem [HIST_BINS];
  logic [CNT_W-1:0]  rd_data_r;

  logic [RCV_W-1:0]  recv_r;
  logic [TOT_W-1:0]  total_r;
  logic [WSUM_W-1:0] wsum_r;
  logic [IDX_W-1:0]  min_r, max_r;
  logic              found_r, ovf_r;

  logic [WSUM_W-1:0]  rem_r;
  logic [WSUM_W-2:0]  dsh_r;
  logic [OIDX_W-1:0]  quo_r;
  logic [DSTEP_W-1:0] dstep_r;
  logic               ge;

  logic [ACC_W-1:0]  t9_r, t19_r, t99_r;
  logic [ACC_W-1:0]  a2_r, a10_r, a20_r, a100_r;
  logic [RCV_W-1:0]  addr_r;
  logic              v1_r, v2_r;
  logic [IDX_W-1:0]  idx1_r, idx2_r;
  logic              f50_r, f90_r, f95_r, f99_r;
  logic [IDX_W-1:0]  p50_r, p90_r, p95_r, p99_r;
  logic              issue;
  logic [ACC_W-1:0]  rd_w;
  logic [ACC_W-1:0]  tot_w;

  assign issue = cmd.scan_step && (addr_r < recv_r);
  assign ge    = rem_r >= {1'b0, dsh_r};
  assign rd_w  = ACC_W'(rd_data_r);
  assign tot_w = ACC_W'(total_r);

  assign stat.div_last   = (dstep_r == DSTEP_W'(DIV_STEPS - 1));
  assign stat.scan_done  = (addr_r >= recv_r) && !v1_r && !v2_r;
  assign stat.total_zero = (total_r == '0);

  // store write and registered read
  always_ff @(posedge clk) begin
    if (cmd.load && (recv_r < RCV_W'(HIST_BINS))) begin
      mem[recv_r[IDX_W-1:0]] <= in_bin_count;
    end
    rd_data_r <= mem[addr_r[IDX_W-1:0]];
  end

  // load-time accumulation
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.emit) begin
      recv_r  <= '0;
      total_r <= '0;
      wsum_r  <= '0;
      min_r   <= '0;
      max_r   <= '0;
      found_r <= 1'b0;
      ovf_r   <= 1'b0;
    end else if (cmd.load) begin
      if (recv_r < RCV_W'(HIST_BINS)) begin
        total_r <= total_r + TOT_W'(in_bin_count);
        wsum_r  <= wsum_r + WSUM_W'(recv_r[IDX_W-1:0]) * WSUM_W'(in_bin_count);
        if (in_bin_count != '0) begin
          if (!found_r) begin
            min_r <= recv_r[IDX_W-1:0];
          end
          found_r <= 1'b1;
          max_r   <= recv_r[IDX_W-1:0];
        end
        recv_r <= recv_r + 1'b1;
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      rem_r   <= wsum_r;
      dsh_r   <= (WSUM_W-1)'(total_r) << (DIV_STEPS - 1);
      quo_r   <= '0;
      dstep_r <= '0;
      t9_r    <= tot_w * ACC_W'(9);
      t19_r   <= tot_w * ACC_W'(19);
      t99_r   <= tot_w * ACC_W'(99);
    end else if (cmd.div_step) begin
      if (ge) begin
        rem_r <= rem_r - WSUM_W'(dsh_r);
      end
      quo_r   <= {quo_r[OIDX_W-2:0], ge};
      dsh_r   <= dsh_r >> 1;
      dstep_r <= dstep_r + 1'b1;
    end
  end

  // scan pipeline: read, accumulate, compare
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.prep) begin
      addr_r <= '0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      a2_r   <= '0;
      a10_r  <= '0;
      a20_r  <= '0;
      a100_r <= '0;
      f50_r  <= 1'b0;
      f90_r  <= 1'b0;
      f95_r  <= 1'b0;
      f99_r  <= 1'b0;
    end else begin
      v1_r <= issue;
      if (issue) begin
        addr_r <= addr_r + 1'b1;
        idx1_r <= addr_r[IDX_W-1:0];
      end
      v2_r <= v1_r;
      if (v1_r) begin
        idx2_r <= idx1_r;
        a2_r   <= a2_r + (rd_w << 1);
        a10_r  <= a10_r + (rd_w << 3) + (rd_w << 1);
        a20_r  <= a20_r + (rd_w << 4) + (rd_w << 2);
        a100_r <= a100_r + (rd_w << 6) + (rd_w << 5) + (rd_w << 2);
      end
      if (v2_r) begin
        if (!f50_r && a2_r >= tot_w) begin
          f50_r <= 1'b1;
          p50_r <= idx2_r;
        end
        if (!f90_r && a10_r >= t9_r) begin
          f90_r <= 1'b1;
          p90_r <= idx2_r;
        end
        if (!f95_r && a20_r >= t19_r) begin
          f95_r <= 1'b1;
          p95_r <= idx2_r;
        end
        if (!f99_r && a100_r >= t99_r) begin
          f99_r <= 1'b1;
          p99_r <= idx2_r;
        end
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
    end
    if (cmd.emit) begin
      out_bins_dropped <= ovf_r;
      if (total_r == '0) begin
        out_total_count <= '0;
        out_min_bin     <= '0;
        out_max_bin     <= '0;
        out_avg_bin     <= '0;
        out_p50_bin     <= '0;
        out_p90_bin     <= '0;
        out_p95_bin     <= '0;
        out_p99_bin     <= '0;
      end else begin
        out_total_count <= total_r;
        out_min_bin     <= OIDX_W'(min_r);
        out_max_bin     <= OIDX_W'(max_r);
        out_avg_bin     <= quo_r;
        out_p50_bin     <= OIDX_W'(p50_r);
        out_p90_bin     <= OIDX_W'(p90_r);
        out_p95_bin     <= OIDX_W'(p95_r);
        out_p99_bin     <= OIDX_W'(p99_r);
      end
    end
  end

  `HLP_ASSERT(a_single_strobe, clk, rst_n, out_valid |=> !out_valid, "result strobe repeated")
  `HLP_ASSERT(a_drop_flag, clk, rst_n, (cmd.load && !cmd.emit && recv_r == RCV_W'(HIST_BINS)) |=> ovf_r, "dropped bin not flagged")
  `HLP_ASSERT(a_pipe_order, clk, rst_n, v2_r |-> $past(v1_r), "scan pipeline out of order")
endmodule

>>> src/histogram_latency_percentiles.sv
// ----------------------------------------------------------------------------
// histogram_latency_percentiles
// Latency histogram statistics: total, min/max bin, average and percentiles.
// ----------------------------------------------------------------------------
//  channel | ports                          | handshake
//  --------+--------------------------------+-------------------------------
//  input   | in_bin_count, in_last_bin      | start high while busy low
//  result  | out_* (nine fields)            | out_valid, one cycle, no stall
//
// A bin request is written to the 1024-entry store; requests past its capacity
// are dropped and flagged. After the request with in_last_bin set the block is
// busy for a prep step, ten divider steps, a scan of one store read per cycle
// through a two-stage pipeline, and a step that loads the result; when the
// total is zero it goes from prep straight to loading the result.
// out_valid follows in the next cycle. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module histogram_latency_percentiles import hlp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [CNT_W-1:0]   in_bin_count,
  input  logic               in_last_bin,
  output logic               out_valid,
  output logic [TOT_W-1:0]   out_total_count,
  output logic [OIDX_W-1:0]  out_min_bin,
  output logic [OIDX_W-1:0]  out_max_bin,
  output logic [OIDX_W-1:0]  out_avg_bin,
  output logic [OIDX_W-1:0]  out_p50_bin,
  output logic [OIDX_W-1:0]  out_p90_bin,
  output logic [OIDX_W-1:0]  out_p95_bin,
  output logic [OIDX_W-1:0]  out_p99_bin,
  output logic               out_bins_dropped
);
  hlp_cmd_t  cmd;
  hlp_stat_t stat;

  // sequencer
  hlp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .last_bin (in_last_bin),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  // store, sums, divider, scan
  hlp_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_bin_count     (in_bin_count),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_total_count  (out_total_count),
    .out_min_bin      (out_min_bin),
    .out_max_bin      (out_max_bin),
    .out_avg_bin      (out_avg_bin),
    .out_p50_bin      (out_p50_bin),
    .out_p90_bin      (out_p90_bin),
    .out_p95_bin      (out_p95_bin),
    .out_p99_bin      (out_p99_bin),
    .out_bins_dropped (out_bins_dropped)
  );
endmodule

>>> bench/tb_histogram_latency_percentiles.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_histogram_latency_percentiles
// Drives latency histograms one bin request at a time and checks every result
// against a behavioral model of the statistics kept inside this bench.
// ----------------------------------------------------------------------------
module tb_histogram_latency_percentiles;
  import hlp_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [CNT_W-1:0]  in_bin_count = '0;
  logic              in_last_bin = 1'b0;
  logic              out_valid;
  logic [TOT_W-1:0]  out_total_count;
  logic [OIDX_W-1:0] out_min_bin, out_max_bin, out_avg_bin;
  logic [OIDX_W-1:0] out_p50_bin, out_p90_bin, out_p95_bin, out_p99_bin;
  logic              out_bins_dropped;

  typedef struct packed {
    logic [TOT_W-1:0]  total;
    logic [OIDX_W-1:0] mn, mx, avg, p50, p90, p95, p99;
    logic              dropped;
  } stats_t;

  histogram_latency_percentiles DUT (.*);

  always #1 clk = ~clk;

  // model state for the histogram in flight
  logic [CNT_W-1:0] hist_bins [HIST_BINS];
  int unsigned      hist_len;
  logic             hist_dropped;
  stats_t           stats_q [$];
  int               errors = 0;
  int               idle_cycles = 0;

  // Recompute the statistics of the stored bins, widths wide enough never to wrap.
  function automatic stats_t compute_stats();
    stats_t s;
    logic [63:0] tot, wsum, cum;
    logic f50, f90, f95, f99, found;
    s = '0;
    tot = 0; wsum = 0; cum = 0; found = 0;
    f50 = 0; f90 = 0; f95 = 0; f99 = 0;
    s.dropped = hist_dropped;
    for (int i = 0; i < hist_len; i++) begin
      tot += hist_bins[i];
      wsum += 64'(i) * hist_bins[i];
      if (hist_bins[i] != 0) begin
        if (!found) begin
          s.mn = OIDX_W'(i);
          found = 1;
        end
        s.mx = OIDX_W'(i);
      end
    end
    if (tot == 0) begin
      s = '0;
      s.dropped = hist_dropped;
      return s;
    end
    s.total = tot[TOT_W-1:0];
    s.avg = OIDX_W'(wsum / tot);
    for (int i = 0; i < hist_len; i++) begin
      cum += hist_bins[i];
      if (!f50 && cum * 2 >= tot) begin s.p50 = OIDX_W'(i); f50 = 1; end
      if (!f90 && cum * 10 >= tot * 9) begin s.p90 = OIDX_W'(i); f90 = 1; end
      if (!f95 && cum * 20 >= tot * 19) begin s.p95 = OIDX_W'(i); f95 = 1; end
      if (!f99 && cum * 100 >= tot * 99) begin s.p99 = OIDX_W'(i); f99 = 1; end
    end
    return s;
  endfunction

  // One bin request: random gap, wait for acceptance, update the model.
  // start stays high after acceptance; the next gap or drain() drops it.
  task automatic send_bin(input logic [CNT_W-1:0] cnt, input logic last);
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_bin_count <= cnt;
    in_last_bin <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (hist_len < HIST_BINS) begin
      hist_bins[hist_len] = cnt;
      hist_len++;
    end else begin
      hist_dropped = 1'b1;
    end
    if (last) begin
      stats_q.push_back(compute_stats());
      hist_len = 0;
      hist_dropped = 1'b0;
    end
  endtask

  // Whole histogram of n bins; kind picks the count distribution.
  task automatic send_hist(input int n, input int kind);
    logic [CNT_W-1:0] c;
    for (int i = 0; i < n; i++) begin
      case (kind)
        0: c = $urandom;
        1: c = $urandom_range(0, 3) == 0 ? $urandom_range(0, 20) : 0;
        2: c = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom;
        default: c = $urandom_range(0, 255);
      endcase
      send_bin(c, i == n - 1);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (stats_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_bin(32'd0, 1'b1);                 // empty single-bin histogram
    send_bin(32'd7, 1'b1);                 // bin zero non-empty
    send_bin(32'hFFFF_FFFF, 1'b1);         // largest count
    send_bin(32'd0, 1'b0); send_bin(32'd0, 1'b0); send_bin(32'd0, 1'b1);
    send_bin(32'd0, 1'b0); send_bin(32'd5, 1'b0); send_bin(32'd0, 1'b1);
    send_bin(32'd1, 1'b0); send_bin(32'd0, 1'b0); send_bin(32'd99, 1'b1);
    send_bin(32'hFFFF_FFFF, 1'b0); send_bin(32'hFFFF_FFFF, 1'b1);
    send_bin(32'hAAAA_AAAA, 1'b0); send_bin(32'h5555_5555, 1'b1);
    drain();                               // sender holds off until all results in
  endtask

  // Store full: bins past capacity are dropped, the last one too, and the
  // widest sums are reached.
  task automatic test_store_full();
    for (int i = 0; i < HIST_BINS + 3; i++)
      send_bin(32'hFFFF_FFFF, i == HIST_BINS + 2);
  endtask

  task automatic test_random();
    int sent;
    int n;
    sent = 0;
    while (sent < 950) begin
      n = $urandom_range(1, 24);
      if ($urandom_range(0, 30) == 0) n = $urandom_range(25, 200);
      send_hist(n, $urandom_range(0, 3));
      sent += n;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    stats_t exp_s, got;
    if (rst_n && out_valid) begin
      got = {out_total_count, out_min_bin, out_max_bin, out_avg_bin, out_p50_bin,
             out_p90_bin, out_p95_bin, out_p99_bin, out_bins_dropped};
      if (stats_q.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $realtime, got);
        errors++;
      end else begin
        exp_s = stats_q.pop_front();
        if (got.total !== exp_s.total) begin
          $display("%0t total: expected %0d actual %0d", $realtime, exp_s.total, got.total);
          errors++;
        end
        if (got.mn !== exp_s.mn) begin
          $display("%0t min: expected %0d actual %0d", $realtime, exp_s.mn, got.mn);
          errors++;
        end
        if (got.mx !== exp_s.mx) begin
          $display("%0t max: expected %0d actual %0d", $realtime, exp_s.mx, got.mx);
          errors++;
        end
        if (got.avg !== exp_s.avg) begin
          $display("%0t avg: expected %0d actual %0d", $realtime, exp_s.avg, got.avg);
          errors++;
        end
        if (got.p50 !== exp_s.p50) begin
          $display("%0t p50: expected %0d actual %0d", $realtime, exp_s.p50, got.p50);
          errors++;
        end
        if (got.p90 !== exp_s.p90) begin
          $display("%0t p90: expected %0d actual %0d", $realtime, exp_s.p90, got.p90);
          errors++;
        end
        if (got.p95 !== exp_s.p95) begin
          $display("%0t p95: expected %0d actual %0d", $realtime, exp_s.p95, got.p95);
          errors++;
        end
        if (got.p99 !== exp_s.p99) begin
          $display("%0t p99: expected %0d actual %0d", $realtime, exp_s.p99, got.p99);
          errors++;
        end
        if (got.dropped !== exp_s.dropped) begin
          $display("%0t dropped: expected %0d actual %0d", $realtime, exp_s.dropped,
                   got.dropped);
          errors++;
        end
      end
    end
  end

  // watchdog: fails the run if no request is accepted and no result arrives within the idle limit
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("histogram_latency_percentiles verification failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_store_full();
    test_random();
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && stats_q.size() == 0)
      $display("histogram_latency_percentiles verification clean");
    else
      $display("histogram_latency_percentiles verification failed");
    $finish;
  end
endmodule
